// ----- hw/rtl/priority_target_table_top_macros.svh -----
// assertion macros for the priority target table
`ifndef PRIORITY_TARGET_TABLE_TOP_MACROS_SVH
`define PRIORITY_TARGET_TABLE_TOP_MACROS_SVH
`define PTT_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("label");
`define PTT_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("label");
`endif

// ----- hw/rtl/ptt_pkg.sv -----
// shared types and constants for the priority target table
package ptt_pkg;
	localparam int DEPTH_DEF = 16;
	localparam int REC_W = 64 + 3 + 32 + 1 + 32;
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SORT = 2'd1;
	localparam logic [1:0] OP_PURGE = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;
	localparam logic [4:0] CAP_RESET = 5'd16;
	localparam logic [31:0] AGE_RESET = 32'd60;
	localparam logic CFG_CAP = 1'b0;
	localparam logic CFG_AGE = 1'b1;

	typedef struct packed {
		logic [63:0] key;
		logic [2:0] priority_lvl;
		logic [31:0] rtime;
		logic active;
		logic [31:0] payload;
	} rec_t;

	typedef struct packed {
		logic [1:0] op;
		logic [63:0] rec_key;
		logic [2:0] rec_priority;
		logic [31:0] rec_time;
		logic rec_active;
		logic [31:0] rec_payload;
		logic [31:0] now_time;
		logic [3:0] read_index;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic [4:0] entry_total;
		logic [63:0] out_key;
		logic [2:0] out_priority;
		logic [31:0] out_time;
		logic out_active;
		logic [31:0] out_payload;
	} rsp_t;
endpackage

// ----- hw/rtl/priority_target_table_top.sv -----
// priority target table top level: sequencer around one record memory
// usage:
//   requests enter on in_valid/in_stall as a req_t; one response per request
//   leaves on out_valid/out_stall as a rsp_t, held until taken.
//   configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
//   index 0 is the capacity limit, index 1 the maximum age.
// steps from the taking of a request to out_valid:
//   read: a registered memory read. add: a key scan, on a full table a
//   priority scan, then a write.
//   purge: one pass that keeps the active entries younger than the maximum
//   age. sort: insertion sort.
//   one request is worked at a time; the next can be taken in the cycle after
//   the response register is loaded.
// reset:
//   arst_n clears the count and restores the registers to 16 and 60;
//   record contents are not cleared, only entries below the count are read.
// stall:
//   a stalled response holds; the next request is still worked and its
//   response waits in the last step until the register is free.
module priority_target_table_top
	import ptt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_SCAN   = 10'b0000000010,
		ST_LOW    = 10'b0000000100,
		ST_WRITE  = 10'b0000001000,
		ST_PURGE  = 10'b0000010000,
		ST_SORTI  = 10'b0000100000,
		ST_SORTJ  = 10'b0001000000,
		ST_READ   = 10'b0010000000,
		ST_RESP   = 10'b0100000000,
		ST_WAIT   = 10'b1000000000
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [CW-1:0] count_q, idx_q, wr_q, ii_q;
	logic [AW-1:0] lo_q, tgt_q;
	logic [2:0] lo_pri_q;
	logic rd_pend_q;
	logic [AW-1:0] rd_idx_q;
	logic acc_q;
	rec_t hold_q;
	logic [4:0] cap_q;
	logic [31:0] age_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	rec_t wdata, rdata;

	ptt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	rec_t new_rec;
	assign new_rec = '{key: req_q.rec_key, priority_lvl: req_q.rec_priority,
		rtime: req_q.rec_time, active: req_q.rec_active, payload: req_q.rec_payload};

	logic [CW-1:0] eff_cap;
	always_comb begin
		if (32'(cap_q) > 32'(TABLE_DEPTH)) begin
			eff_cap = CW'(TABLE_DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	logic [31:0] age_v;
	assign age_v = req_q.now_time - rdata.rtime;

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// memory address and write steering
	always_comb begin
		we = 1'b0;
		waddr = tgt_q;
		wdata = new_rec;
		raddr = idx_q[AW-1:0];
		case (state_q)
			ST_WRITE: begin
				we = 1'b1;
			end
			ST_PURGE: begin
				we = rd_pend_q && (age_v < age_q) && rdata.active;
				waddr = wr_q[AW-1:0];
				wdata = rdata;
			end
			ST_SORTI: begin
				raddr = ii_q[AW-1:0];
			end
			ST_SORTJ: begin
				waddr = tgt_q;
				if (rd_pend_q && rdata.priority_lvl < hold_q.priority_lvl) begin
					we = 1'b1;
					wdata = rdata;
				end else if (rd_pend_q || tgt_q == '0) begin
					we = 1'b1;
					wdata = hold_q;
				end
				raddr = tgt_q - AW'(1);
			end
			ST_READ, ST_RESP: begin
				raddr = AW'(req_q.read_index);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			cap_q <= CAP_RESET;
			age_q <= AGE_RESET;
			rd_pend_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_RESP) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CAP: cap_q <= cfg_data[4:0];
					CFG_AGE: age_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q <= in_data;
						idx_q <= '0;
						wr_q <= '0;
						rd_pend_q <= 1'b0;
						acc_q <= 1'b1;
						case (in_data.op)
							OP_ADD: state_q <= ST_SCAN;
							OP_SORT: begin
								ii_q <= CW'(1);
								state_q <= ST_SORTI;
							end
							OP_PURGE: state_q <= ST_PURGE;
							default: state_q <= ST_READ;
						endcase
					end
				end
				ST_SCAN: begin
					// key match scan, rdata belongs to idx_q-1
					if (rd_pend_q && rdata.key == req_q.rec_key) begin
						tgt_q <= rd_idx_q;
						rd_pend_q <= 1'b0;
						state_q <= ST_WRITE;
					end else if (idx_q >= count_q) begin
						rd_pend_q <= 1'b0;
						if (count_q < eff_cap) begin
							tgt_q <= count_q[AW-1:0];
							count_q <= count_q + CW'(1);
							state_q <= ST_WRITE;
						end else if (count_q == '0) begin
							acc_q <= 1'b0;
							state_q <= ST_RESP;
						end else begin
							idx_q <= '0;
							lo_q <= '0;
							lo_pri_q <= 3'd7;
							state_q <= ST_LOW;
						end
					end else begin
						rd_pend_q <= 1'b1;
						rd_idx_q <= idx_q[AW-1:0];
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_LOW: begin
					if (rd_pend_q && (rd_idx_q == '0 || rdata.priority_lvl < lo_pri_q)) begin
						lo_q <= rd_idx_q;
						lo_pri_q <= rdata.priority_lvl;
					end
					if (idx_q >= count_q) begin
						rd_pend_q <= 1'b0;
						if (!rd_pend_q) begin
							tgt_q <= lo_q;
							if (req_q.rec_priority > lo_pri_q) begin
								state_q <= ST_WRITE;
							end else begin
								acc_q <= 1'b0;
								state_q <= ST_RESP;
							end
						end
					end else begin
						rd_pend_q <= 1'b1;
						rd_idx_q <= idx_q[AW-1:0];
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_WRITE: begin
					state_q <= ST_RESP;
				end
				ST_PURGE: begin
					if (we) begin
						wr_q <= wr_q + CW'(1);
					end
					if (idx_q >= count_q) begin
						rd_pend_q <= 1'b0;
						if (!rd_pend_q) begin
							count_q <= wr_q;
							state_q <= ST_RESP;
						end
					end else begin
						rd_pend_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_SORTI: begin
					// fetch the element to insert
					if (ii_q >= count_q) begin
						state_q <= ST_RESP;
					end else if (!rd_pend_q) begin
						idx_q <= ii_q;
						rd_pend_q <= 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					hold_q <= rdata;
					tgt_q <= ii_q[AW-1:0];
					rd_pend_q <= 1'b0;
					state_q <= ST_SORTJ;
				end
				ST_SORTJ: begin
					// rd_pend_q: rdata holds entry tgt_q-1
					if (!rd_pend_q) begin
						if (tgt_q == '0) begin
							ii_q <= ii_q + CW'(1);
							state_q <= ST_SORTI;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else if (rdata.priority_lvl < hold_q.priority_lvl) begin
						tgt_q <= tgt_q - AW'(1);
						rd_pend_q <= 1'b0;
					end else begin
						rd_pend_q <= 1'b0;
						ii_q <= ii_q + CW'(1);
						state_q <= ST_SORTI;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid <= 1'b1;
						out_data.accepted <= acc_q;
						out_data.entry_total <= 5'(count_q);
						if (req_q.op == OP_READ && CW'(req_q.read_index) < count_q) begin
							out_data.out_key <= rdata.key;
							out_data.out_priority <= rdata.priority_lvl;
							out_data.out_time <= rdata.rtime;
							out_data.out_active <= rdata.active;
							out_data.out_payload <= rdata.payload;
						end else begin
							out_data.out_key <= '0;
							out_data.out_priority <= '0;
							out_data.out_time <= '0;
							out_data.out_active <= 1'b0;
							out_data.out_payload <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "priority_target_table_top_macros.svh"

	`PTT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`PTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`PTT_ASSERT_IMP(a_no_take_busy, clk, arst_n, state_q != ST_IDLE, in_stall)
	`PTT_ASSERT_IMP(a_no_cfg_busy, clk, arst_n, state_q != ST_IDLE, !cfg_ready)
endmodule

// ----- hw/rtl/ptt_ram.sv -----
// generic single-port-write, one-read ram with registered read
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
